>>> sv/aoci_pkg.sv
`timescale 1ns / 1ps

package aoci_pkg;

   // Number of points on the wavelength grid.
   localparam int TABLE_POINTS = 57;

   // Field widths.
   localparam int WL_W = 16;
   localparam int RI_W = 15;
   localparam int EX_W = 18;

   // Index widths: a bin addresses TABLE_POINTS-1 intervals, a point addresses the grid.
   localparam int BIN_W = $clog2(TABLE_POINTS - 1);
   localparam int IDX_W = $clog2(TABLE_POINTS);

   // Datapath widths. The widest bin spans 382 tenths of a nanometre and the largest
   // step between neighbouring table entries is 5400.
   localparam int OFF_W       = 9;
   localparam int DIFF_W      = 16;
   localparam int PROD_W      = OFF_W + 1 + DIFF_W;
   localparam int MAG_W       = 22;
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 28;
   localparam int QUO_W       = 16;

   localparam logic [WL_W-1:0] GRID [TABLE_POINTS] = '{
      16'd3000, 16'd3100, 16'd3179, 16'd3263, 16'd3351, 16'd3444, 16'd3500, 16'd3542,
      16'd3647, 16'd3757, 16'd3875, 16'd4000, 16'd4133, 16'd4275, 16'd4428, 16'd4500,
      16'd4592, 16'd4769, 16'd4959, 16'd5000, 16'd5061, 16'd5166, 16'd5276, 16'd5391,
      16'd5500, 16'd5510, 16'd5636, 16'd5767, 16'd5904, 16'd6000, 16'd6048, 16'd6199,
      16'd6358, 16'd6500, 16'd6526, 16'd6702, 16'd6888, 16'd7000, 16'd7085, 16'd7293,
      16'd7500, 16'd7514, 16'd7749, 16'd7999, 16'd8250, 16'd8266, 16'd8500, 16'd8551,
      16'd8750, 16'd8856, 16'd9000, 16'd9184, 16'd9250, 16'd9500, 16'd9537, 16'd9919,
      16'd10000
   };

   localparam logic [RI_W-1:0] INDEX_TAB [TABLE_POINTS] = '{
      15'd2760,  15'd2940,  15'd3100,  15'd3260,  15'd3440,  15'd3640,  15'd3750,
      15'd3850,  15'd4070,  15'd4320,  15'd4600,  15'd4900,  15'd5230,  15'd5580,
      15'd5980,  15'd6180,  15'd6440,  15'd6950,  15'd7550,  15'd7690,  15'd7890,
      15'd8260,  15'd8670,  15'd9120,  15'd9580,  15'd9630,  15'd10200, 15'd10800,
      15'd11500, 15'd12000, 15'd12200, 15'd13000, 15'd13900, 15'd14700, 15'd14900,
      15'd16000, 15'd17400, 15'd18300, 15'd19100, 15'd21400, 15'd24000, 15'd24100,
      15'd26300, 15'd28000, 15'd27500, 15'd27400, 15'd26100, 15'd25800, 15'd23800,
      15'd22400, 15'd20600, 15'd18600, 15'd17700, 15'd14900, 15'd15800, 15'd13700,
      15'd13500
   };

   localparam logic signed [EX_W-1:0] EXT_TAB [TABLE_POINTS] = '{
      -18'sd36100, -18'sd37400, -18'sd38400, -18'sd39500, -18'sd40600, -18'sd41700,
      -18'sd42400, -18'sd43000, -18'sd44300, -18'sd45600, -18'sd47100, -18'sd48600,
      -18'sd50200, -18'sd52000, -18'sd53800, -18'sd54700, -18'sd55800, -18'sd58000,
      -18'sd60300, -18'sd60800, -18'sd61500, -18'sd62800, -18'sd64200, -18'sd65500,
      -18'sd66900, -18'sd67000, -18'sd68500, -18'sd70000, -18'sd71500, -18'sd72600,
      -18'sd73100, -18'sd74800, -18'sd76500, -18'sd77900, -18'sd78200, -18'sd80100,
      -18'sd82100, -18'sd83100, -18'sd83900, -18'sd85700, -18'sd86200, -18'sd86200,
      -18'sd86000, -18'sd84500, -18'sd83100, -18'sd83100, -18'sd82200, -18'sd82100,
      -18'sd81800, -18'sd82100, -18'sd83000, -18'sd84400, -18'sd84900, -18'sd88800,
      -18'sd89500, -18'sd94900, -18'sd95800
   };

   // Result of the bin search, handed to the interpolator.
   typedef struct packed {
      logic [WL_W-1:0]  wavelength;
      logic [BIN_W-1:0] bin;
      logic             below;
      logic             above;
   } bin_info_type;

endpackage

>>> sv/aoci_req_if.sv
`timescale 1ns / 1ps

interface aoci_req_if;
   logic                           valid;
   logic                           ready;
   logic [aoci_pkg::WL_W-1:0]      wavelength;

   modport source (output valid, output wavelength, input ready);
   modport sink (input valid, input wavelength, output ready);
endinterface

>>> sv/aoci_rsp_if.sv
`timescale 1ns / 1ps

interface aoci_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [aoci_pkg::RI_W-1:0]           refractive_index;
   logic signed [aoci_pkg::EX_W-1:0]    extinction;

   modport source (output valid, output refractive_index, output extinction, input ready);
   modport sink (input valid, input refractive_index, input extinction, output ready);
endinterface

>>> sv/aoci_bin_search.sv
`timescale 1ns / 1ps

module aoci_bin_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [aoci_pkg::WL_W-1:0]     in_wavelength,
   output logic                          out_valid,
   input  logic                          out_ready,
   output aoci_pkg::bin_info_type        out_info
);

   logic                                   v1_ff;
   logic                                   v2_ff;
   logic                                   load1;
   logic                                   load2;
   logic [aoci_pkg::TABLE_POINTS-1:0]      ge_in;
   logic [aoci_pkg::TABLE_POINTS-1:0]      ge_ff;
   logic [aoci_pkg::WL_W-1:0]              wl1_ff;
   aoci_pkg::bin_info_type                 info_in;
   aoci_pkg::bin_info_type                 info_ff;

   assign load2    = !v2_ff || out_ready;
   assign load1    = !v1_ff || load2;
   assign in_ready = load1;

   // Stage one: compare against every grid point at once.
   always_comb begin
      for (int i = 0; i < aoci_pkg::TABLE_POINTS; i++) begin
         ge_in[i] = in_wavelength >= aoci_pkg::GRID[i];
      end
   end

   // Stage two: the comparisons form a thermometer code; its single edge names the bin.
   always_comb begin
      info_in.wavelength = wl1_ff;
      info_in.below      = !ge_ff[0];
      info_in.above      = ge_ff[aoci_pkg::TABLE_POINTS-1];
      info_in.bin        = '0;
      for (int i = 0; i < aoci_pkg::TABLE_POINTS - 1; i++) begin
         info_in.bin = info_in.bin |
            ((ge_ff[i] && !ge_ff[i+1]) ? aoci_pkg::BIN_W'(i) : aoci_pkg::BIN_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= in_valid;
         if (load2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         ge_ff  <= ge_in;
         wl1_ff <= in_wavelength;
      end
      if (load2) info_ff <= info_in;
   end

   assign out_valid = v2_ff;
   assign out_info  = info_ff;

`ifndef ASSERT_OFF
   a_bin_holds_wavelength: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !info_ff.below && !info_ff.above) |->
         (info_ff.wavelength >= aoci_pkg::GRID[aoci_pkg::IDX_W'(info_ff.bin)] &&
          info_ff.wavelength < aoci_pkg::GRID[aoci_pkg::IDX_W'(info_ff.bin) + 1'b1]))
      else $error("bin search chose a bin that does not hold the wavelength");
`endif

endmodule

>>> sv/aoci_lerp.sv
`timescale 1ns / 1ps

module aoci_lerp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  aoci_pkg::bin_info_type              in_info,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [aoci_pkg::RI_W-1:0]           out_refractive_index,
   output logic signed [aoci_pkg::EX_W-1:0]    out_extinction
);

   localparam int NB = aoci_pkg::TABLE_POINTS - 1;

   logic v3_ff, v4_ff, v5_ff, v6_ff;
   logic load3, load4, load5, load6;

   // Reciprocals of the bin widths, rounded up, so that a product and a shift
   // give the truncated quotient exactly for every operand this block can meet.
   logic [aoci_pkg::RECIP_W-1:0] recip_tab [NB];

   for (genvar g = 0; g < NB; g++) begin : g_recip
      localparam longint SPAN = longint'(aoci_pkg::GRID[g+1]) - longint'(aoci_pkg::GRID[g]);
      localparam longint RECIP = ((longint'(1) <<< aoci_pkg::RECIP_SHIFT) + SPAN - 1) / SPAN;
      assign recip_tab[g] = aoci_pkg::RECIP_W'(RECIP);
   end

   // Stage three: table lookup.
   logic [aoci_pkg::IDX_W-1:0]            pt_lo;
   logic [aoci_pkg::IDX_W-1:0]            pt_hi;
   logic [aoci_pkg::OFF_W-1:0]            off_in, off3_ff;
   logic [aoci_pkg::RECIP_W-1:0]          recip3_ff, recip4_ff;
   logic [aoci_pkg::RI_W-1:0]             ri_a0_in, ri_a0_3_ff, ri_a0_4_ff, ri_a0_5_ff;
   logic signed [aoci_pkg::EX_W-1:0]      ex_a0_in, ex_a0_3_ff, ex_a0_4_ff, ex_a0_5_ff;
   logic signed [aoci_pkg::DIFF_W-1:0]    ri_diff_in, ri_diff3_ff;
   logic signed [aoci_pkg::DIFF_W-1:0]    ex_diff_in, ex_diff3_ff;

   always_comb begin
      pt_lo = aoci_pkg::IDX_W'(in_info.bin);
      pt_hi = pt_lo + 1'b1;
      off_in = aoci_pkg::OFF_W'(in_info.wavelength - aoci_pkg::GRID[pt_lo]);
      if (in_info.below || in_info.above) off_in = '0;
      ri_diff_in = aoci_pkg::DIFF_W'($signed({1'b0, aoci_pkg::INDEX_TAB[pt_hi]}) -
                                     $signed({1'b0, aoci_pkg::INDEX_TAB[pt_lo]}));
      ex_diff_in = aoci_pkg::DIFF_W'(aoci_pkg::EXT_TAB[pt_hi] - aoci_pkg::EXT_TAB[pt_lo]);
      if (in_info.above) begin
         ri_a0_in = aoci_pkg::INDEX_TAB[aoci_pkg::TABLE_POINTS-1];
         ex_a0_in = aoci_pkg::EXT_TAB[aoci_pkg::TABLE_POINTS-1];
      end else begin
         ri_a0_in = aoci_pkg::INDEX_TAB[pt_lo];
         ex_a0_in = aoci_pkg::EXT_TAB[pt_lo];
      end
   end

   // Stage four: offset times step, split into sign and magnitude.
   logic signed [aoci_pkg::PROD_W-1:0]    ri_prod, ex_prod;
   logic [aoci_pkg::MAG_W-1:0]            ri_mag_in, ex_mag_in, ri_mag4_ff, ex_mag4_ff;
   logic                                  ri_neg4_ff, ex_neg4_ff, ri_neg5_ff, ex_neg5_ff;

   always_comb begin
      ri_prod   = $signed({1'b0, off3_ff}) * ri_diff3_ff;
      ex_prod   = $signed({1'b0, off3_ff}) * ex_diff3_ff;
      ri_mag_in = aoci_pkg::MAG_W'(ri_prod[aoci_pkg::PROD_W-1] ? -ri_prod : ri_prod);
      ex_mag_in = aoci_pkg::MAG_W'(ex_prod[aoci_pkg::PROD_W-1] ? -ex_prod : ex_prod);
   end

   // Stage five: divide the magnitude by the bin width through its reciprocal.
   logic [aoci_pkg::MAG_W+aoci_pkg::RECIP_W-1:0] ri_full, ex_full;
   logic [aoci_pkg::QUO_W-1:0]                   ri_q_in, ex_q_in, ri_q5_ff, ex_q5_ff;

   always_comb begin
      ri_full = ri_mag4_ff * recip4_ff;
      ex_full = ex_mag4_ff * recip4_ff;
      ri_q_in = aoci_pkg::QUO_W'(ri_full >> aoci_pkg::RECIP_SHIFT);
      ex_q_in = aoci_pkg::QUO_W'(ex_full >> aoci_pkg::RECIP_SHIFT);
   end

   // Stage six: restore the sign and add the lower bin end.
   logic [aoci_pkg::RI_W-1:0]             ri_in, ri6_ff;
   logic signed [aoci_pkg::EX_W-1:0]      ex_in, ex6_ff;

   always_comb begin
      ri_in = aoci_pkg::RI_W'(int'(ri_a0_5_ff) +
                              (ri_neg5_ff ? -int'(ri_q5_ff) : int'(ri_q5_ff)));
      ex_in = aoci_pkg::EX_W'(int'(ex_a0_5_ff) +
                              (ex_neg5_ff ? -int'(ex_q5_ff) : int'(ex_q5_ff)));
   end

   assign load6    = !v6_ff || out_ready;
   assign load5    = !v5_ff || load6;
   assign load4    = !v4_ff || load5;
   assign load3    = !v3_ff || load4;
   assign in_ready = load3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (load3) v3_ff <= in_valid;
         if (load4) v4_ff <= v3_ff;
         if (load5) v5_ff <= v4_ff;
         if (load6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         off3_ff     <= off_in;
         recip3_ff   <= recip_tab[in_info.bin];
         ri_a0_3_ff  <= ri_a0_in;
         ex_a0_3_ff  <= ex_a0_in;
         ri_diff3_ff <= ri_diff_in;
         ex_diff3_ff <= ex_diff_in;
      end
      if (load4) begin
         ri_mag4_ff <= ri_mag_in;
         ex_mag4_ff <= ex_mag_in;
         ri_neg4_ff <= ri_prod[aoci_pkg::PROD_W-1];
         ex_neg4_ff <= ex_prod[aoci_pkg::PROD_W-1];
         recip4_ff  <= recip3_ff;
         ri_a0_4_ff <= ri_a0_3_ff;
         ex_a0_4_ff <= ex_a0_3_ff;
      end
      if (load5) begin
         ri_q5_ff   <= ri_q_in;
         ex_q5_ff   <= ex_q_in;
         ri_neg5_ff <= ri_neg4_ff;
         ex_neg5_ff <= ex_neg4_ff;
         ri_a0_5_ff <= ri_a0_4_ff;
         ex_a0_5_ff <= ex_a0_4_ff;
      end
      if (load6) begin
         ri6_ff <= ri_in;
         ex6_ff <= ex_in;
      end
   end

   assign out_valid            = v6_ff;
   assign out_refractive_index = ri6_ff;
   assign out_extinction       = ex6_ff;

`ifndef ASSERT_OFF
   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && load4) |=> v4_ff)
      else $error("a transaction leaving the lookup stage was lost");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> (ri6_ff <= 15'd28000 && ex6_ff >= -18'sd95800 && ex6_ff <= -18'sd36100))
      else $error("interpolated result outside the table range");
`endif

endmodule

>>> sv/aluminium_optical_constant_interp_unit.sv
`timescale 1ns / 1ps

// Aluminium optical constants by piecewise linear interpolation.
//
// The request channel (req_if) carries one wavelength per transaction, in tenths of a
// nanometre. The response channel (rsp_if) returns, for each request and in order, the
// refractive index and the extinction coefficient (negative convention), both scaled by
// 10000. The 57-point grid runs from 300.0 nm to 1000.0 nm; wavelengths below it give
// the first table entries and wavelengths at or above its top give the last ones.
//
// The datapath is six register stages: two for the bin search (compare against every
// grid point, then encode the thermometer edge), then lookup, offset-times-step
// multiply, reciprocal multiply and final add. One transaction is accepted every
// cycle while the response side keeps up.
//
// Each stage holds its item when the stage after it is full and stalled, so a stall on
// the response side fills the empty stages first and only then drops req_if.ready.
// Nothing is lost or repeated. Synchronous reset empties the pipeline; there is no
// other state to clear and no start-up sweep.

module aluminium_optical_constant_interp_unit (
   input  logic        clock,
   input  logic        reset,
   aoci_req_if.sink    req_if,
   aoci_rsp_if.source  rsp_if
);

   aoci_pkg::bin_info_type  bin_info;
   logic                    bin_valid;
   logic                    bin_ready;

   // Bin search across the whole grid.
   aoci_bin_search u_bin_search (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_if.valid),
      .in_ready      (req_if.ready),
      .in_wavelength (req_if.wavelength),
      .out_valid     (bin_valid),
      .out_ready     (bin_ready),
      .out_info      (bin_info)
   );

   // Interpolation of both tables within the chosen bin.
   aoci_lerp u_lerp (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (bin_valid),
      .in_ready             (bin_ready),
      .in_info              (bin_info),
      .out_valid            (rsp_if.valid),
      .out_ready            (rsp_if.ready),
      .out_refractive_index (rsp_if.refractive_index),
      .out_extinction       (rsp_if.extinction)
   );

`ifndef ASSERT_OFF
   a_ready_when_output_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("request side blocked although the response register is empty");
`endif

endmodule

>>> bench/aoci_optics_checker.sv
`timescale 1ns / 1ps

module aoci_optics_checker (
   input  logic  clock,
   input  logic  reset,
   aoci_req_if   req,
   aoci_rsp_if   rsp,
   output int    error_count,
   output int    pending_count
);

   typedef struct packed {
      logic [aoci_pkg::WL_W-1:0]        wavelength;
      logic [aoci_pkg::RI_W-1:0]        index;
      logic signed [aoci_pkg::EX_W-1:0] ext;
   } optics_expect_type;

   localparam int POINT_TENTHS [aoci_pkg::TABLE_POINTS] = '{
      3000, 3100, 3179, 3263, 3351, 3444, 3500, 3542, 3647, 3757,
      3875, 4000, 4133, 4275, 4428, 4500, 4592, 4769, 4959, 5000,
      5061, 5166, 5276, 5391, 5500, 5510, 5636, 5767, 5904, 6000,
      6048, 6199, 6358, 6500, 6526, 6702, 6888, 7000, 7085, 7293,
      7500, 7514, 7749, 7999, 8250, 8266, 8500, 8551, 8750, 8856,
      9000, 9184, 9250, 9500, 9537, 9919, 10000
   };

   localparam int INDEX_X10K [aoci_pkg::TABLE_POINTS] = '{
      2760, 2940, 3100, 3260, 3440, 3640, 3750, 3850, 4070, 4320,
      4600, 4900, 5230, 5580, 5980, 6180, 6440, 6950, 7550, 7690,
      7890, 8260, 8670, 9120, 9580, 9630, 10200, 10800, 11500, 12000,
      12200, 13000, 13900, 14700, 14900, 16000, 17400, 18300, 19100, 21400,
      24000, 24100, 26300, 28000, 27500, 27400, 26100, 25800, 23800, 22400,
      20600, 18600, 17700, 14900, 15800, 13700, 13500
   };

   localparam int EXT_X10K [aoci_pkg::TABLE_POINTS] = '{
      -36100, -37400, -38400, -39500, -40600, -41700, -42400, -43000, -44300, -45600,
      -47100, -48600, -50200, -52000, -53800, -54700, -55800, -58000, -60300, -60800,
      -61500, -62800, -64200, -65500, -66900, -67000, -68500, -70000, -71500, -72600,
      -73100, -74800, -76500, -77900, -78200, -80100, -82100, -83100, -83900, -85700,
      -86200, -86200, -86000, -84500, -83100, -83100, -82200, -82100, -81800, -82100,
      -83000, -84400, -84900, -88800, -89500, -94900, -95800
   };

   optics_expect_type expected_optics [$];

   // The quotient is truncated toward zero, as signed integer division does.
   function automatic longint lerp_table(input longint a0, input longint a1,
                                         input longint l0, input longint l1,
                                         input longint w);
      longint span;
      span = l1 - l0;
      if (span <= 0) return a0;
      return a0 + ((w - l0) * (a1 - a0)) / span;
   endfunction

   function automatic optics_expect_type predict_optics(
      input logic [aoci_pkg::WL_W-1:0] wl);
      optics_expect_type r;
      longint            w;
      longint            ri;
      longint            ex;
      int                seg;
      w   = longint'(wl);
      seg = 0;
      if (w < POINT_TENTHS[0]) begin
         ri = INDEX_X10K[0];
         ex = EXT_X10K[0];
      end else if (w >= POINT_TENTHS[aoci_pkg::TABLE_POINTS-1]) begin
         ri = INDEX_X10K[aoci_pkg::TABLE_POINTS-1];
         ex = EXT_X10K[aoci_pkg::TABLE_POINTS-1];
      end else begin
         for (int i = 1; i < aoci_pkg::TABLE_POINTS - 1; i++) begin
            if (w >= POINT_TENTHS[i]) seg = i;
         end
         ri = lerp_table(INDEX_X10K[seg], INDEX_X10K[seg+1],
                         POINT_TENTHS[seg], POINT_TENTHS[seg+1], w);
         ex = lerp_table(EXT_X10K[seg], EXT_X10K[seg+1],
                         POINT_TENTHS[seg], POINT_TENTHS[seg+1], w);
      end
      r.wavelength = wl;
      r.index      = ri[aoci_pkg::RI_W-1:0];
      r.ext        = ex[aoci_pkg::EX_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $realtime, msg);
      error_count++;
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Results are checked before requests are recorded; the pipeline never returns a
   // result in the cycle of its own request.
   always @(posedge clock) begin
      optics_expect_type want;
      if (reset) begin
         expected_optics.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_optics.size() == 0) begin
               report_mismatch($sformatf("unexpected result: index %0d extinction %0d",
                                         rsp.refractive_index, $signed(rsp.extinction)));
            end else begin
               want = expected_optics.pop_front();
               if (rsp.refractive_index !== want.index)
                  report_mismatch($sformatf("wavelength %0d: index expected %0d got %0d",
                                            want.wavelength, want.index,
                                            rsp.refractive_index));
               if (rsp.extinction !== want.ext)
                  report_mismatch($sformatf("wavelength %0d: extinction expected %0d got %0d",
                                            want.wavelength, $signed(want.ext),
                                            $signed(rsp.extinction)));
            end
         end
         if (req.valid && req.ready)
            expected_optics.push_back(predict_optics(req.wavelength));
      end
      pending_count <= expected_optics.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Top level of the bench. It only makes stimulus and gives the verdict; prediction and
// comparison live in the checker instantiated beside the block.
module tb_top;

   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 205;
   localparam int HOLD_CYCLES     = 300;
   localparam int HOLD_BURST      = 40;
   localparam int IDLE_LIMIT      = 2000;
   localparam int TAIL_CYCLES     = 20;

   // Ways in which the receiver applies back-pressure.
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PERIODIC
   } ready_mode_type;

   logic clock;
   logic reset;

   aoci_req_if req_if ();
   aoci_rsp_if rsp_if ();

   int             error_count;
   int             pending_count;
   int             idle_cycles;
   int             burst_left;
   int             gap_max;
   int             hold_requests;
   int             hold_served;
   int             hold_left;
   int             rx_cycle;
   ready_mode_type ready_mode;

   aluminium_optical_constant_interp_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   aoci_optics_checker u_optics_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog counts cycles in which no transaction is accepted on either channel.
   // A correct run never goes quiet for long: the longest deliberate stall is the
   // receiver hold-off, well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $realtime, pending_count);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // The receiver drives ready at the falling edge. A hold-off request from the
   // stimulus process is served here, and its length is counted here too, so that the
   // sender is free to keep offering transactions while the pipeline fills up.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_if.ready <= 1'b0;
         hold_served  <= hold_served + 1;
         hold_left    <= HOLD_CYCLES - 1;
      end else begin
         case (ready_mode)
            READY_ALWAYS:   rsp_if.ready <= 1'b1;
            READY_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM:   rsp_if.ready <= ($urandom_range(0, 9) < 3);
            READY_PERIODIC: rsp_if.ready <= ((rx_cycle % 7) < 4);
            default:        rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // Offers one wavelength from a falling edge and returns at the falling edge after
   // the transaction has been accepted. Valid is left high, so back-to-back items
   // need no second assignment to it in the same step.
   task automatic send_item(input logic [aoci_pkg::WL_W-1:0] wl);
      req_if.valid      <= 1'b1;
      req_if.wavelength <= wl;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // The sender works in bursts; between bursts it idles for a random number of cycles
   // with junk on the payload lines, so gaps land on every stage of the pipeline.
   task automatic send_paced(input logic [aoci_pkg::WL_W-1:0] wl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_if.valid      <= 1'b0;
            req_if.wavelength <= aoci_pkg::WL_W'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_item(wl);
   endtask

   // Stops offering and waits until every outstanding result has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Most wavelengths fall inside the grid, where the bin search and the interpolation
   // do their work; the rest sit on grid points, next to them, around the clamping
   // edges, or anywhere in the 16-bit range.
   function automatic logic [aoci_pkg::WL_W-1:0] pick_wavelength();
      int sel;
      int k;
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, aoci_pkg::TABLE_POINTS - 1);
      if (sel < 60)      return aoci_pkg::WL_W'($urandom_range(3000, 9999));
      else if (sel < 72) return aoci_pkg::GRID[k];
      else if (sel < 84) return ($urandom_range(0, 1) != 0) ?
                                aoci_pkg::GRID[k] + 16'd1 : aoci_pkg::GRID[k] - 16'd1;
      else if (sel < 94) return aoci_pkg::WL_W'($urandom_range(0, 65535));
      else if (sel < 97) return aoci_pkg::WL_W'($urandom_range(2990, 3010));
      else               return aoci_pkg::WL_W'($urandom_range(9990, 10010));
   endfunction

   initial begin
      logic [aoci_pkg::WL_W-1:0] directed [$];

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.wavelength = '0;
      rsp_if.ready      = 1'b0;
      idle_cycles       = 0;
      burst_left        = 0;
      gap_max           = 0;
      hold_requests     = 0;
      hold_served       = 0;
      hold_left         = 0;
      rx_cycle          = 0;
      ready_mode        = READY_ALWAYS;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: the ends of the field, both clamps and their edges, exact grid
      // points including the index peak, and points inside bins whose step is
      // positive, negative and zero.
      directed = '{16'd0, 16'd65535, 16'd2999, 16'd3000, 16'd3001, 16'd3050,
                   16'd9999, 16'd10000, 16'd10001, 16'd3100, 16'd5500, 16'd7999,
                   16'd8100, 16'd7507, 16'd8258, 16'd9919, 16'd9918, 16'd9520,
                   16'd32767, 16'd32768, 16'd21845, 16'd43690, 16'd6000, 16'd4500};
      foreach (directed[i]) send_paced(directed[i]);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin ready_mode = READY_ALWAYS;   gap_max = 0; end
            1: begin ready_mode = READY_MOSTLY;   gap_max = 4; end
            2: begin ready_mode = READY_SELDOM;   gap_max = 8; end
            3: begin ready_mode = READY_PERIODIC; gap_max = 3; end
            4: begin ready_mode = READY_MOSTLY;   gap_max = 0; end
            default: begin ready_mode = READY_ALWAYS; gap_max = 6; end
         endcase

         // Long receiver hold-off with the sender pushing back-to-back, so the
         // pipeline fills and the request side stalls.
         if (phase == 3) begin
            hold_requests++;
            repeat (HOLD_BURST) send_item(pick_wavelength());
         end

         for (int n = 0; n < PHASE_ITEMS; n++) send_paced(pick_wavelength());

         // Pause with nothing offered until the pipeline has emptied.
         if (phase == 2) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/aoci_pkg.sv
sv/aoci_req_if.sv
sv/aoci_rsp_if.sv
sv/aoci_bin_search.sv
sv/aoci_lerp.sv
sv/aluminium_optical_constant_interp_unit.sv
bench/aoci_optics_checker.sv
bench/tb_top.sv
